// ===== sv/bkr_pkg.sv =====
`default_nettype none

package bkr_pkg;

  // Width of one stream word.
  localparam int unsigned DataW = 32;

  // Width of the group size register.
  localparam int unsigned GsizeW = 5;

  // Controller states, one-hot.
  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  // Shift command for the cell chain.
  typedef struct packed {
    logic en;  // move every cell by one place this cycle
    logic up;  // 1: toward higher index, 0: toward lower index
  } shift_ctl_t;

endpackage

`default_nettype wire

// ===== sv/bkr_cell.sv =====
`default_nettype none

module bkr_cell
  import bkr_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire shift_ctl_t               ctl_i,
  input  wire logic signed [DataW-1:0]  left_i,
  input  wire logic signed [DataW-1:0]  right_i,
  output logic signed [DataW-1:0]       value_o
);

  logic signed [DataW-1:0] value_q;
  logic signed [DataW-1:0] value_d;

  // Take the word from the lower neighbor when shifting up, else from the upper one.
  always_comb begin
    value_d = value_q;
    if (ctl_i.en) begin
      value_d = ctl_i.up ? left_i : right_i;
    end
  end

  // Payload only, so no reset.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

// ===== sv/block_reverse_k_group.sv =====
// Stream reverser in groups of k. Words arrive on the slave stream, one a
// cycle while a group fills; they enter a chain of MAX_GROUP cells at cell 0
// and move one cell up per word. When the group reaches the programmed size
// (group_size, 0 read as 1, values above MAX_GROUP read as MAX_GROUP), or a
// word with tlast ends the sequence, the input stalls and the held words
// leave one a cycle while the master stream accepts them: a full group
// newest first by shifting the chain down, a short tail in arrival order
// by shifting the chain up past the oldest cell. No new word is taken
// until a group has drained, since the single chain both fills and
// drains. The final word of a sequence carries tlast. An output register
// decouples the master stream, so backpressure only extends the drain.
// group_size is at byte address 0 of the APB port and should be written
// only while the block is idle.
`default_nettype none

module block_reverse_k_group
  import bkr_pkg::*;
#(
  parameter int unsigned MAX_GROUP = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // Slave stream: tdata = item_value[31:0], tlast = item_last.
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic signed [DataW-1:0] s_axis_tdata,
  input  wire logic                    s_axis_tlast,
  // Master stream: tdata = out_value[31:0], tlast = out_last.
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic signed [DataW-1:0]      m_axis_tdata,
  output logic                         m_axis_tlast,
  // APB configuration port.
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [2:0]              paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned CntW = $clog2(MAX_GROUP + 1);
  localparam int unsigned IdxW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_GROUP);
  localparam logic [GsizeW-1:0] GsizeRst = GsizeW'(2);
  localparam logic [2:0] AddrGsize = 3'd0;

  state_e                  state_q, state_d;
  logic [GsizeW-1:0]       gsize_q;
  logic [CntW-1:0]         fill_q, fill_d;
  logic [CntW-1:0]         remain_q, remain_d;
  logic [IdxW-1:0]         top_q, top_d;
  logic                    rev_q, rev_d;
  logic                    seq_last_q, seq_last_d;
  logic                    mvalid_q, mvalid_d;
  logic signed [DataW-1:0] mdata_q, mdata_d;
  logic                    mlast_q, mlast_d;

  logic [CntW-1:0]         keff;
  logic [CntW+GsizeW-1:0]  gsize_ext;
  logic [CntW-1:0]         fill_inc;
  logic                    in_acc;
  logic                    out_load;
  shift_ctl_t              shift_ctl;
  logic signed [DataW-1:0] cell_val [MAX_GROUP];

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = {{(32-GsizeW){1'b0}}, gsize_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gsize_q <= GsizeRst;
    end else if (psel && penable && pwrite && pready && paddr == AddrGsize) begin
      gsize_q <= pwdata[GsizeW-1:0];
    end
  end

  // Effective group size: zero reads as one, large values saturate.
  assign gsize_ext = (CntW+GsizeW)'(gsize_q);
  always_comb begin
    if (gsize_q == '0) begin
      keff = CntW'(1);
    end else if (gsize_ext > (CntW+GsizeW)'(MAX_GROUP)) begin
      keff = MaxCnt;
    end else begin
      keff = gsize_ext[CntW-1:0];
    end
  end

  assign s_axis_tready = (state_q == ST_FILL);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_DRAIN) && (!mvalid_q || m_axis_tready);
  assign fill_inc      = fill_q + CntW'(1);

  // Controller: fill the chain, then drain it word by word.
  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    remain_d   = remain_q;
    top_d      = top_q;
    rev_d      = rev_q;
    seq_last_d = seq_last_q;
    mvalid_d   = mvalid_q;
    mdata_d    = mdata_q;
    mlast_d    = mlast_q;
    shift_ctl  = '{en: 1'b0, up: 1'b1};

    if (m_axis_tready) begin
      mvalid_d = 1'b0;
    end

    case (state_q)
      ST_FILL: begin
        if (in_acc) begin
          shift_ctl = '{en: 1'b1, up: 1'b1};
          fill_d    = fill_inc;
          if (fill_inc >= keff || s_axis_tlast) begin
            state_d    = ST_DRAIN;
            fill_d     = '0;
            remain_d   = fill_inc;
            top_d      = IdxW'(fill_q);
            rev_d      = (fill_inc >= keff);
            seq_last_d = s_axis_tlast;
          end
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          shift_ctl = '{en: 1'b1, up: !rev_q};
          mvalid_d  = 1'b1;
          mdata_d   = rev_q ? cell_val[0] : cell_val[top_q];
          mlast_d   = seq_last_q && (remain_q == CntW'(1));
          remain_d  = remain_q - CntW'(1);
          if (remain_q == CntW'(1)) begin
            state_d = ST_FILL;
          end
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FILL;
      fill_q     <= '0;
      remain_q   <= '0;
      top_q      <= '0;
      rev_q      <= 1'b0;
      seq_last_q <= 1'b0;
      mvalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      remain_q   <= remain_d;
      top_q      <= top_d;
      rev_q      <= rev_d;
      seq_last_q <= seq_last_d;
      mvalid_q   <= mvalid_d;
    end
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    mdata_q <= mdata_d;
    mlast_q <= mlast_d;
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;
  assign m_axis_tlast  = mlast_q;

  // Chain of cells; cell 0 takes new words from the slave stream.
  for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
    logic signed [DataW-1:0] left_w;
    logic signed [DataW-1:0] right_w;
    if (i == 0) begin : g_head
      assign left_w = s_axis_tdata;
    end else begin : g_body
      assign left_w = cell_val[i-1];
    end
    if (i == MAX_GROUP - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = cell_val[i+1];
    end
    bkr_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (shift_ctl),
      .left_i  (left_w),
      .right_i (right_w),
      .value_o (cell_val[i])
    );
  end

  // A group never holds more words than the chain has cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q < MaxCnt)
    else $error("fill count reached chain length");

  // A drain always has at least one word left to send.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |-> remain_q != '0)
    else $error("drain with no words left");

  // The end of a sequence always starts a drain and empties the group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tlast |=> state_q == ST_DRAIN && fill_q == '0)
    else $error("sequence end did not start a drain");

  // A word flagged last is the final word of its drain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && mlast_d |=> state_q == ST_FILL)
    else $error("last word sent before drain finished");

endmodule

`default_nettype wire
